// ----- rtl/rotated_page_framebuffer_core_macros.svh -----
// assertion macros for the rotated page framebuffer core
// no dependencies; included by the files that carry concurrent assertions
`ifndef ROTATED_PAGE_FRAMEBUFFER_CORE_MACROS_SVH
`define ROTATED_PAGE_FRAMEBUFFER_CORE_MACROS_SVH

// generic clocked assertion with an active-low reset
`define RPFB_ASSERT_AT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion on the usual clk_i / rst_ni pair
`define RPFB_ASSERT(label, prop, msg) \
  `RPFB_ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/rpfb_pkg.sv -----
// shared constants, codes and types of the rotated page framebuffer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rpfb_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 160;
  localparam int PIX_PER_BYTE = 8;
  localparam int PAGES      = (MAX_HEIGHT + PIX_PER_BYTE - 1) / PIX_PER_BYTE;
  localparam int DEPTH      = MAX_WIDTH * PAGES;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int PROD_W     = ADDR_W + 1;
  localparam int WID_W      = 9;
  localparam int HGT_W      = 8;
  localparam int PAGE_W     = $clog2(PAGES + 1);
  localparam int COORD_W    = 8;

  // transaction modes
  localparam logic [1:0] MODE_PIXEL = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_ROTATION = 2'd0;
  localparam logic [1:0] CFG_WIDTH    = 2'd1;
  localparam logic [1:0] CFG_HEIGHT   = 2'd2;

  // rotation codes, quarter turns
  localparam logic [1:0] ROT_NONE = 2'd0;
  localparam logic [1:0] ROT_90   = 2'd1;
  localparam logic [1:0] ROT_180  = 2'd2;
  localparam logic [1:0] ROT_270  = 2'd3;

  // result of coordinate mapping for one transaction
  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        mask;
    logic [ADDR_W-1:0] last;
  } map_t;

endpackage

`default_nettype wire

// ----- rtl/rpfb_store.sv -----
// frame byte store: one write port, one read port, registered read data
// depends on rpfb_pkg
`timescale 1ns / 1ps
`default_nettype none

module rpfb_store
  import rpfb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [7:0]        wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [7:0]        rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/rpfb_map.sv -----
// coordinate rotation, bounds check and byte address computation
// depends on rpfb_pkg
`timescale 1ns / 1ps
`default_nettype none

module rpfb_map
  import rpfb_pkg::*;
(
  input  wire logic [1:0]         rotation_i,
  input  wire logic [WID_W-1:0]   width_i,
  input  wire logic [HGT_W-1:0]   height_i,
  input  wire logic [1:0]         mode_i,
  input  wire logic [COORD_W-1:0] x_i,
  input  wire logic [COORD_W-1:0] y_i,
  input  wire logic [ADDR_W-1:0]  index_i,
  output map_t                    map_o
);

  logic [WID_W-1:0]   w;
  logic [HGT_W-1:0]   h;
  logic [PAGE_W-1:0]  pages;
  logic [PROD_W-1:0]  total;
  logic [WID_W-1:0]   x_lim;
  logic [WID_W-1:0]   y_lim;
  logic               xy_ok;
  logic               idx_ok;
  logic [COORD_W-1:0] wm1;
  logic [COORD_W-1:0] hm1;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic [PROD_W-1:0]  pix_addr;

  always_comb begin
    // saturate the size registers into their legal ranges
    if (width_i == '0) w = WID_W'(1);
    else if (width_i > WID_W'(MAX_WIDTH)) w = WID_W'(MAX_WIDTH);
    else w = width_i;
    if (height_i == '0) h = HGT_W'(1);
    else if ({1'b0, height_i} > WID_W'(MAX_HEIGHT)) h = HGT_W'(MAX_HEIGHT);
    else h = height_i;

    pages = PAGE_W'(({1'b0, h} + WID_W'(PIX_PER_BYTE - 1)) >> 3);
    total = PROD_W'(w) * PROD_W'(pages);

    // odd quarter turns swap the logical axes
    x_lim = rotation_i[0] ? {1'b0, h} : w;
    if (rotation_i[0]) y_lim = w;
    else y_lim = {1'b0, h};
    xy_ok = ({1'b0, x_i} < x_lim) && ({1'b0, y_i} < y_lim);

    wm1 = COORD_W'(w - WID_W'(1));
    hm1 = h - HGT_W'(1);

    case (rotation_i)
      ROT_NONE: begin
        col = x_i;
        row = y_i;
      end
      ROT_90: begin
        col = wm1 - y_i;
        row = x_i;
      end
      ROT_180: begin
        col = wm1 - x_i;
        row = hm1 - y_i;
      end
      default: begin
        col = y_i;
        row = hm1 - x_i;
      end
    endcase

    pix_addr = PROD_W'(col) + PROD_W'(row[7:3]) * PROD_W'(w);
    idx_ok   = {1'b0, index_i} < total;

    map_o.mask = 8'(1) << row[2:0];
    map_o.last = ADDR_W'(total - PROD_W'(1));
    map_o.addr = (mode_i == MODE_READ) ? index_i : ADDR_W'(pix_addr);

    unique case (mode_i)
      MODE_PIXEL: map_o.ok = xy_ok;
      MODE_CLEAR: map_o.ok = 1'b1;
      MODE_READ:  map_o.ok = idx_ok;
      default:    map_o.ok = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/rotated_page_framebuffer_core.sv -----
// Monochrome page framebuffer with coordinate rotation. Pixels live in a
// 5120-byte synchronous store, eight vertical pixels per byte, byte address
// column + page * width, so linear byte order is the panel flush order. Each
// input transaction carries a mode: 0 writes one pixel (rotated by 0/90/180/270
// degrees, bounds checked, then set or cleared by read-modify-write), 1 clears
// the active part of the store, 2 reads one byte by linear index. Every
// transaction gives exactly one result transaction with a status bit (1 for
// an out-of-range coordinate, index or unused mode) and the read byte.
// Sequence: pixel writes and byte reads go through accept, map, store read,
// then write back with the result; a clear goes through accept and map, then
// writes one byte per cycle over width * pages bytes; a rejected transaction
// goes from map straight to its result. The store has one read and one write port.
// After reset all 5120 bytes of the store are swept to zero with s_axis_tready low;
// configuration writes are taken at any time but must only change while idle.
// A finished result sits in an output register, so the next transaction is
// accepted while the previous result still waits.
// depends on rpfb_pkg, rpfb_map, rpfb_store, rotated_page_framebuffer_core_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "rotated_page_framebuffer_core_macros.svh"

module rotated_page_framebuffer_core
  import rpfb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [8:0]  cfg_wdata_i,
  // input transactions
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // mode[1:0], x_coord[9:2], y_coord[17:10], pixel_on[18], read_index[31:19]
  input  wire logic [31:0] s_axis_tdata,
  // result transactions
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[0], read_data[8:1], zero fill[15:9]
  output logic [15:0]      m_axis_tdata
);

  // sequencer states
  localparam logic [2:0] ST_INIT = 3'd0;  // sweep store to zero after reset
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_MAP  = 3'd2;  // rotate and compute the address
  localparam logic [2:0] ST_ACC  = 3'd3;  // store read issued
  localparam logic [2:0] ST_WB   = 3'd4;  // modify, write back, give result
  localparam logic [2:0] ST_CLR  = 3'd5;  // clear sweep over active bytes
  localparam logic [2:0] ST_DONE = 3'd6;  // hand over a result with no store access

  logic [2:0] state_q, state_d;

  // configuration registers
  logic [1:0]       rotation_q;
  logic [WID_W-1:0] width_q;
  logic [HGT_W-1:0] height_q;

  // captured transaction fields
  logic [1:0]         mode_q;
  logic [COORD_W-1:0] x_q;
  logic [COORD_W-1:0] y_q;
  logic               on_q;
  logic [ADDR_W-1:0]  idx_q;

  map_t map_w;
  map_t map_q;

  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [ADDR_W-1:0] clr_last_q;
  logic              res_status_q, res_status_d;

  // output register
  logic       out_valid_q, out_valid_d;
  logic       out_status_q, out_status_d;
  logic [7:0] out_data_q, out_data_d;
  logic       out_free;
  logic       out_load;

  // store ports
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [7:0]        mem_rdata;
  logic              sweep;
  logic              in_fire;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // configuration writes; index beyond the list is ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_q <= 2'd0;
      width_q    <= WID_W'(MAX_WIDTH);
      height_q   <= HGT_W'(MAX_HEIGHT);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ROTATION: rotation_q <= cfg_wdata_i[1:0];
        CFG_WIDTH:    width_q    <= cfg_wdata_i;
        CFG_HEIGHT:   height_q   <= cfg_wdata_i[HGT_W-1:0];
        default:      ;
      endcase
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q <= s_axis_tdata[1:0];
      x_q    <= s_axis_tdata[9:2];
      y_q    <= s_axis_tdata[17:10];
      on_q   <= s_axis_tdata[18];
      idx_q  <= s_axis_tdata[31:19];
    end
    if (state_q == ST_MAP) begin
      map_q      <= map_w;
      clr_last_q <= map_w.last;
    end
  end

  rpfb_map u_map (
    .rotation_i (rotation_q),
    .width_i    (width_q),
    .height_i   (height_q),
    .mode_i     (mode_q),
    .x_i        (x_q),
    .y_i        (y_q),
    .index_i    (idx_q),
    .map_o      (map_w)
  );

  // store access
  assign sweep     = (state_q == ST_INIT) || (state_q == ST_CLR);
  assign mem_re    = (state_q == ST_ACC);
  assign mem_we    = sweep ||
                     ((state_q == ST_WB) && out_free && (mode_q == MODE_PIXEL));
  assign mem_waddr = sweep ? cnt_q : map_q.addr;
  assign mem_wdata = sweep ? 8'd0 :
                     (on_q ? (mem_rdata | map_q.mask) : (mem_rdata & ~map_q.mask));

  rpfb_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (map_q.addr),
    .rdata_o (mem_rdata)
  );

  // sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    out_load     = 1'b0;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;

    unique case (state_q)
      ST_INIT: begin
        cnt_d = cnt_q + ADDR_W'(1);
        if (cnt_q == ADDR_W'(DEPTH - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) state_d = ST_MAP;
      end
      ST_MAP: begin
        if (!map_w.ok) begin
          res_status_d = 1'b1;
          state_d      = ST_DONE;
        end else if (mode_q == MODE_CLEAR) begin
          cnt_d   = '0;
          state_d = ST_CLR;
        end else begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        state_d = ST_WB;
      end
      ST_WB: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = 1'b0;
          out_data_d   = (mode_q == MODE_READ) ? mem_rdata : 8'd0;
          state_d      = ST_IDLE;
        end
      end
      ST_CLR: begin
        cnt_d = cnt_q + ADDR_W'(1);
        if (cnt_q == clr_last_q) begin
          res_status_d = 1'b0;
          state_d      = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = res_status_q;
          out_data_d   = 8'd0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_load) out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      cnt_q        <= '0;
      res_status_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      res_status_q <= res_status_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_data_q, out_status_q};

  // store writes only happen in sweeps or write-back
  `RPFB_ASSERT(a_we_state, mem_we |-> (sweep || (state_q == ST_WB)), "store write outside sweep or write-back")
  // a result is never loaded over one that is still held
  `RPFB_ASSERT(a_out_no_overrun, out_load |-> (!out_valid_q || m_axis_tready), "result overwritten")
  // an accepted transaction moves to mapping
  `RPFB_ASSERT(a_accept_map, in_fire |=> (state_q == ST_MAP), "accept did not start mapping")
  // the clear sweep stays inside the active bytes
  `RPFB_ASSERT(a_clr_bound, (state_q == ST_CLR) |-> (cnt_q <= clr_last_q), "clear ran past active bytes")
  // write-back is only reached for an in-range transaction
  `RPFB_ASSERT(a_wb_ok, (state_q == ST_WB) |-> map_q.ok, "write-back of a rejected transaction")

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// self-checking testbench for rotated_page_framebuffer_core: pixel writes under all
// four rotations, clears and byte reads, checked against an in-bench frame model
// depends on rpfb_pkg and the core
`timescale 1ns / 1ps

module testbench;
  import rpfb_pkg::*;

  // codes the package does not name
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;

  localparam int IDLE_LIMIT   = 20000;  // covers the reset sweep and a full-size clear
  localparam int HOLDOFF_LEN  = 300;
  localparam int SETTLE_LEN   = 20;
  localparam int MAX_REPORTS  = 30;
  localparam int NUM_PHASES   = 10;

  // one input transaction; packed msb first so it lines up with s_axis_tdata
  typedef struct packed {
    logic [12:0] read_index;
    logic        pixel_on;
    logic [7:0]  y;
    logic [7:0]  x;
    logic [1:0]  mode;
  } fb_cmd_t;

  typedef struct packed {
    logic       status;
    logic [7:0] read_data;
  } fb_resp_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_index_i   = '0;
  logic [8:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  rotated_page_framebuffer_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // register settings walked through after the directed part; zero and
  // over-range sizes exercise the saturation of width and height
  int phase_rot    [NUM_PHASES] = '{1, 2, 3, 0, 3, 1, 2, 3, 0, 2};
  int phase_width  [NUM_PHASES] = '{16, 1, 0, 37, 511, 256, 200, 24, 9, 64};
  int phase_height [NUM_PHASES] = '{12, 1, 0, 160, 255, 8, 255, 33, 17, 100};
  int phase_items  [NUM_PHASES] = '{200, 120, 80, 200, 150, 200, 150, 300, 200, 250};
  bit phase_quiet  [NUM_PHASES] = '{0, 0, 0, 1, 0, 0, 0, 0, 0, 0};
  bit phase_hold   [NUM_PHASES] = '{1, 0, 0, 0, 0, 0, 0, 1, 0, 0};

  // mirror of the configuration registers and of the pixel store
  logic [1:0]  rot_q;
  logic [8:0]  width_q;
  logic [7:0]  height_q;
  logic [7:0]  shadow_frame [DEPTH];

  fb_cmd_t     cmd_queue [$];     // transactions waiting to be offered
  fb_resp_t    resp_queue [$];    // responses owed by the core, oldest first
  int          touched [$];       // recently written byte addresses, to aim reads
  fb_cmd_t     cur_cmd;
  fb_resp_t    got_resp;
  fb_resp_t    want_resp;

  bit          quiet        = 1'b0;
  int          holdoff_reqs = 0;
  int          holdoff_seen = 0;
  int          hold_left    = 0;
  int          idle_cycles  = 0;
  int          errors       = 0;
  int          n_resp       = 0;
  int          n_rejected   = 0;
  int          mode_count [4] = '{0, 0, 0, 0};

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int eff_width();
    if (width_q == 0) return 1;
    if (width_q > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_q);
  endfunction

  function automatic int eff_height();
    if (height_q == 0) return 1;
    if (height_q > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(height_q);
  endfunction

  // applies one transaction to the shadow frame and returns the owed response
  function automatic fb_resp_t fb_apply_cmd(input fb_cmd_t c);
    fb_resp_t   r;
    int         w, h, bytes, xi, yi, col, row, addr;
    bit         hit;
    logic [7:0] bitmask;
    w = eff_width();
    h = eff_height();
    bytes = w * ((h + 7) / 8);
    xi = int'(c.x);
    yi = int'(c.y);
    col = 0;
    row = 0;
    hit = 1'b0;
    r.status = 1'b1;
    r.read_data = '0;
    mode_count[c.mode]++;
    case (c.mode)
      MODE_PIXEL: begin
        // logical to panel coordinate, bounds follow the rotated frame
        case (rot_q)
          ROT_NONE: begin
            hit = xi < w && yi < h; col = xi;         row = yi;
          end
          ROT_90: begin
            hit = xi < h && yi < w; col = w - 1 - yi; row = xi;
          end
          ROT_180: begin
            hit = xi < w && yi < h; col = w - 1 - xi; row = h - 1 - yi;
          end
          default: begin
            hit = xi < h && yi < w; col = yi;         row = h - 1 - xi;
          end
        endcase
        if (hit) begin
          addr = col + (row / 8) * w;
          bitmask = 8'd1 << (row % 8);
          if (c.pixel_on) shadow_frame[addr] = shadow_frame[addr] | bitmask;
          else shadow_frame[addr] = shadow_frame[addr] & ~bitmask;
          touched.push_back(addr);
          if (touched.size() > 32) void'(touched.pop_front());
          r.status = 1'b0;
        end
      end
      MODE_CLEAR: begin
        // only the active part of the store is wiped
        for (int i = 0; i < bytes; i++) shadow_frame[i] = '0;
        r.status = 1'b0;
      end
      MODE_READ: begin
        if (int'(c.read_index) < bytes) begin
          r.read_data = shadow_frame[c.read_index];
          r.status = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // random transaction shaped by the current settings: mostly in-range pixels
  // and reads aimed at written bytes, with some noise and rare clears
  function automatic fb_cmd_t gen_cmd();
    fb_cmd_t c;
    int      w, h, bytes, pick, clr, xl, yl, sel;
    w = eff_width();
    h = eff_height();
    bytes = w * ((h + 7) / 8);
    c = fb_cmd_t'($urandom);
    clr = (bytes <= 1024) ? 3 : 1;
    pick = $urandom_range(0, 99);
    if (pick < clr) begin
      c.mode = MODE_CLEAR;
    end else if (pick < clr + 3) begin
      c.mode = MODE_UNUSED;
    end else if (pick < 58) begin
      c.mode = MODE_PIXEL;
      if ($urandom_range(0, 4) != 0) begin
        xl = (rot_q == ROT_90 || rot_q == ROT_270) ? h : w;
        yl = (rot_q == ROT_90 || rot_q == ROT_270) ? w : h;
        c.x = 8'($urandom_range(0, xl - 1));
        c.y = 8'($urandom_range(0, yl - 1));
      end
    end else begin
      c.mode = MODE_READ;
      sel = $urandom_range(0, 99);
      if (sel < 45 && touched.size() > 0) begin
        c.read_index = 13'(touched[$urandom_range(0, touched.size() - 1)]);
      end else if (sel < 80) begin
        c.read_index = 13'($urandom_range(0, bytes - 1));
      end
    end
    return c;
  endfunction

  function automatic fb_cmd_t mk_cmd(input logic [1:0] mode, input int x, input int y,
                                     input bit on, input int idx);
    fb_cmd_t c;
    c.mode = mode;
    c.x = 8'(x);
    c.y = 8'(y);
    c.pixel_on = on;
    c.read_index = 13'(idx);
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_REPORTS) $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // returns once nothing is queued, offered or owed
  task automatic wait_idle();
    @(negedge clk_i);
    while (cmd_queue.size() != 0 || s_axis_tvalid || resp_queue.size() != 0)
      @(negedge clk_i);
  endtask

  // register mirror, sampled on the same edge as the core
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q <= ROT_NONE;
      width_q <= 9'd256;
      height_q <= 8'd160;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROTATION: rot_q <= cfg_wdata_i[1:0];
        CFG_WIDTH:    width_q <= cfg_wdata_i;
        CFG_HEIGHT:   height_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // input side: predict on each accepted transaction, then offer the next one
  // unless a random gap is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      for (int i = 0; i < DEPTH; i++) shadow_frame[i] = '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) resp_queue.push_back(fb_apply_cmd(cur_cmd));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_queue.size() > 0 && (quiet || $urandom_range(0, 99) >= 10)) begin
          cur_cmd = cmd_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= cur_cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side: check each accepted response against the oldest owed one,
  // with random stalls and the occasional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_resp.status = m_axis_tdata[0];
        got_resp.read_data = m_axis_tdata[8:1];
        if (resp_queue.size() == 0) begin
          report_mismatch($sformatf("response with none owed, data %h", m_axis_tdata));
        end else begin
          want_resp = resp_queue.pop_front();
          n_resp++;
          if (want_resp.status) n_rejected++;
          if (got_resp.status !== want_resp.status)
            report_mismatch($sformatf("response %0d status %b, owed %b", n_resp,
                                      got_resp.status, want_resp.status));
          if (got_resp.read_data !== want_resp.read_data)
            report_mismatch($sformatf("response %0d read_data %h, owed %h", n_resp,
                                      got_resp.read_data, want_resp.read_data));
        end
      end
      if (holdoff_reqs != holdoff_seen) begin
        holdoff_seen = holdoff_reqs;
        hold_left = HOLDOFF_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || $urandom_range(0, 99) >= 10;
      end
    end
  end

  // ends the run when no transaction moves on either side for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction in %0d cycles", IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int remaining, n;
    bit first;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part at the reset settings: fresh store, frame corners,
    // out-of-range pixels and indexes, bit set and clear in one byte,
    // the unused mode, and a full clear
    @(negedge clk_i);
    cmd_queue.push_back(mk_cmd(MODE_READ, 0, 0, 0, 0));
    cmd_queue.push_back(mk_cmd(MODE_READ, 0, 0, 0, DEPTH - 1));
    cmd_queue.push_back(mk_cmd(MODE_PIXEL, 0, 0, 1, 0));
    cmd_queue.push_back(mk_cmd(MODE_PIXEL, 255, 159, 1, 0));
    cmd_queue.push_back(mk_cmd(MODE_PIXEL, 255, 160, 1, 0));
    cmd_queue.push_back(mk_cmd(MODE_PIXEL, 255, 255, 1, 8191));
    cmd_queue.push_back(mk_cmd(MODE_READ, 255, 255, 1, 0));
    cmd_queue.push_back(mk_cmd(MODE_READ, 0, 0, 0, DEPTH - 1));
    cmd_queue.push_back(mk_cmd(MODE_READ, 0, 0, 0, DEPTH));
    cmd_queue.push_back(mk_cmd(MODE_READ, 0, 0, 0, 8191));
    cmd_queue.push_back(mk_cmd(MODE_PIXEL, 7, 8, 1, 0));
    cmd_queue.push_back(mk_cmd(MODE_PIXEL, 7, 15, 1, 0));
    cmd_queue.push_back(mk_cmd(MODE_READ, 0, 0, 0, 263));
    cmd_queue.push_back(mk_cmd(MODE_PIXEL, 7, 8, 0, 0));
    cmd_queue.push_back(mk_cmd(MODE_READ, 0, 0, 0, 263));
    cmd_queue.push_back(mk_cmd(MODE_UNUSED, 255, 255, 1, 0));
    cmd_queue.push_back(mk_cmd(MODE_READ, 0, 0, 0, 0));
    cmd_queue.push_back(mk_cmd(MODE_CLEAR, 255, 255, 1, 8191));
    cmd_queue.push_back(mk_cmd(MODE_READ, 0, 0, 0, 0));
    cmd_queue.push_back(mk_cmd(MODE_READ, 0, 0, 0, DEPTH - 1));
    cmd_queue.push_back(mk_cmd(MODE_READ, 0, 0, 0, 263));

    for (int p = 0; p < NUM_PHASES; p++) begin
      // registers change only with the core idle
      wait_idle();
      repeat (SETTLE_LEN) @(posedge clk_i);
      write_reg(CFG_ROTATION, {7'($urandom), 2'(phase_rot[p])});
      write_reg(CFG_WIDTH, 9'(phase_width[p]));
      write_reg(CFG_HEIGHT, {1'($urandom), 8'(phase_height[p])});
      write_reg(CFG_UNUSED, 9'($urandom));
      @(negedge clk_i);
      quiet = phase_quiet[p];
      remaining = phase_items[p];
      first = 1'b1;
      while (remaining > 0) begin
        // a hold-off phase starts with a deep backlog so the core backs up
        n = (first && phase_hold[p]) ? 60 : $urandom_range(1, 60);
        if (n > remaining) n = remaining;
        @(negedge clk_i);
        repeat (n) cmd_queue.push_back(gen_cmd());
        if (first && phase_hold[p]) holdoff_reqs++;
        first = 1'b0;
        remaining -= n;
        if ($urandom_range(0, 4) == 0) begin
          wait_idle();
        end else begin
          while (cmd_queue.size() > 4) @(negedge clk_i);
        end
      end
      quiet = 1'b0;
    end

    wait_idle();
    repeat (SETTLE_LEN) @(posedge clk_i);
    $display("ran %0d pixel, %0d clear, %0d read and %0d unused-mode commands over %0d settings",
             mode_count[MODE_PIXEL], mode_count[MODE_CLEAR], mode_count[MODE_READ],
             mode_count[MODE_UNUSED], NUM_PHASES + 1);
    $display("checked %0d responses, %0d of them rejections, %0d mismatches",
             n_resp, n_rejected, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
